// ----- rtl/pse_pkg.sv -----
package pse_pkg;

  localparam int FRAC_BITS = 12;
  localparam int DATA_W    = 16;
  localparam int ERR_W     = DATA_W + 1;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int SUM_W     = 32;
  localparam int PROD_P_W  = DATA_W + ERR_W;
  localparam int PROD_I_W  = DATA_W + SUM_W;
  localparam int PROD_D_W  = DATA_W + DIFF_W;
  localparam int ACC_W     = PROD_I_W + 1;
  localparam int SCALED_W  = ACC_W - FRAC_BITS;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [DATA_W-1:0] GAIN_PROP_RESET  = DATA_W'(7660);
  localparam logic signed [DATA_W-1:0] GAIN_INTEG_RESET = DATA_W'(279);
  localparam logic signed [DATA_W-1:0] GAIN_DERIV_RESET = DATA_W'(4874);
  localparam logic [DATA_W-1:0]        SEP_LIMIT_RESET  = DATA_W'(300);

  // added to a negative sum before the arithmetic shift so it truncates toward zero
  localparam logic [ACC_W-1:0] TRUNC_BIAS = (ACC_W'(1) << FRAC_BITS) - ACC_W'(1);

  localparam logic signed [DATA_W-1:0] DRIVE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DRIVE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0]  SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]  SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP  = 2'd0,
    REG_GAIN_INTEG = 2'd1,
    REG_GAIN_DERIV = 2'd2,
    REG_SEP_LIMIT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_prop;
    logic signed [DATA_W-1:0] gain_integ;
    logic signed [DATA_W-1:0] gain_deriv;
    logic [DATA_W-1:0]        separation_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  esum;
  } terms_t;

  typedef struct packed {
    logic signed [PROD_P_W-1:0] prop;
    logic signed [PROD_I_W-1:0] integ;
    logic signed [PROD_D_W-1:0] deriv;
  } prods_t;

endpackage

// ----- rtl/pse_state.sv -----
module pse_state (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic signed [pse_pkg::DATA_W-1:0] target_speed,
  input  logic signed [pse_pkg::DATA_W-1:0] measured_speed,
  input  pse_pkg::cfg_t                  cfg,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output pse_pkg::terms_t                terms
);

  logic signed [pse_pkg::ERR_W-1:0]  err;
  logic [pse_pkg::ERR_W-1:0]         err_mag;
  logic                              admit;
  logic signed [pse_pkg::SUM_W:0]    sum_wide;
  logic signed [pse_pkg::SUM_W-1:0]  sum_sat;
  logic signed [pse_pkg::DIFF_W-1:0] diff;
  logic signed [pse_pkg::SUM_W-1:0]  error_sum;
  logic signed [pse_pkg::SUM_W-1:0]  error_sum_next;
  logic signed [pse_pkg::ERR_W-1:0]  previous_error;
  logic                              take;

  assign up_ready = !dn_valid || dn_ready;
  assign take     = up_valid && up_ready;

  always_comb begin
    err = {target_speed[pse_pkg::DATA_W-1], target_speed}
        - {measured_speed[pse_pkg::DATA_W-1], measured_speed};
    err_mag = err[pse_pkg::ERR_W-1] ? pse_pkg::ERR_W'(-err) : pse_pkg::ERR_W'(err);
    admit = err_mag <= {1'b0, cfg.separation_limit};
    sum_wide = {error_sum[pse_pkg::SUM_W-1], error_sum}
             + {{(pse_pkg::SUM_W+1-pse_pkg::ERR_W){err[pse_pkg::ERR_W-1]}}, err};
    // saturate when the carry disagrees with the sign
    if (sum_wide[pse_pkg::SUM_W] != sum_wide[pse_pkg::SUM_W-1]) begin
      sum_sat = sum_wide[pse_pkg::SUM_W] ? pse_pkg::SUM_MIN : pse_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_wide[pse_pkg::SUM_W-1:0];
    end
    error_sum_next = admit ? sum_sat : error_sum;
    diff = {err[pse_pkg::ERR_W-1], err} - {previous_error[pse_pkg::ERR_W-1], previous_error};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid       <= 1'b0;
      error_sum      <= '0;
      previous_error <= '0;
    end else begin
      if (up_ready) begin
        dn_valid <= up_valid;
      end
      if (take) begin
        error_sum      <= error_sum_next;
        previous_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      terms.err  <= err;
      terms.diff <= diff;
      terms.esum <= error_sum_next;
    end
  end

endmodule

// ----- rtl/pse_mult.sv -----
module pse_mult (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  pse_pkg::terms_t terms,
  input  pse_pkg::cfg_t   cfg,
  output logic            dn_valid,
  input  logic            dn_ready,
  output pse_pkg::prods_t prods
);

  logic signed [pse_pkg::PROD_P_W-1:0] prop;
  logic signed [pse_pkg::PROD_I_W-1:0] integ;
  logic signed [pse_pkg::PROD_D_W-1:0] deriv;

  assign up_ready = !dn_valid || dn_ready;

  assign prop  = $signed(cfg.gain_prop)  * $signed(terms.err);
  assign integ = $signed(cfg.gain_integ) * $signed(terms.esum);
  assign deriv = $signed(cfg.gain_deriv) * $signed(terms.diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      prods.prop  <= prop;
      prods.integ <= integ;
      prods.deriv <= deriv;
    end
  end

endmodule

// ----- rtl/pse_out.sv -----
module pse_out (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  pse_pkg::prods_t                    prods,
  output logic                               dn_valid,
  input  logic                               dn_stall,
  output logic signed [pse_pkg::DATA_W-1:0]  drive_value
);

  logic                             acc_valid;
  logic                             acc_ready;
  logic                             out_ready;
  logic signed [pse_pkg::ACC_W-1:0] acc;
  logic signed [pse_pkg::ACC_W-1:0] acc_next;
  logic signed [pse_pkg::ACC_W-1:0] biased;
  logic signed [pse_pkg::SCALED_W-1:0] scaled;
  logic [pse_pkg::SCALED_W-pse_pkg::DATA_W:0] upper;
  logic signed [pse_pkg::DATA_W-1:0] drive_next;

  assign out_ready = !dn_valid || !dn_stall;
  assign acc_ready = !acc_valid || out_ready;
  assign up_ready  = acc_ready;

  always_comb begin
    acc_next =
        {{(pse_pkg::ACC_W-pse_pkg::PROD_P_W){prods.prop[pse_pkg::PROD_P_W-1]}}, prods.prop}
      + {{(pse_pkg::ACC_W-pse_pkg::PROD_I_W){prods.integ[pse_pkg::PROD_I_W-1]}}, prods.integ}
      + {{(pse_pkg::ACC_W-pse_pkg::PROD_D_W){prods.deriv[pse_pkg::PROD_D_W-1]}}, prods.deriv};
  end

  always_comb begin
    biased = acc + (acc[pse_pkg::ACC_W-1] ? pse_pkg::TRUNC_BIAS : '0);
    scaled = biased[pse_pkg::ACC_W-1:pse_pkg::FRAC_BITS];
    upper  = scaled[pse_pkg::SCALED_W-1:pse_pkg::DATA_W-1];
    // in range only when every bit above the result's sign matches it
    if (upper == '0 || upper == '1) begin
      drive_next = scaled[pse_pkg::DATA_W-1:0];
    end else begin
      drive_next = scaled[pse_pkg::SCALED_W-1] ? pse_pkg::DRIVE_MIN : pse_pkg::DRIVE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
      dn_valid  <= 1'b0;
    end else begin
      if (acc_ready) begin
        acc_valid <= up_valid;
      end
      if (out_ready) begin
        dn_valid <= acc_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && acc_ready) begin
      acc <= acc_next;
    end
    if (acc_valid && out_ready) begin
      drive_value <= drive_next;
    end
  end

endmodule

// ----- rtl/pid_speed_integral_separation.sv -----
// channel   valid         stall         payload
// sample    sample_valid  sample_stall  target_speed, measured_speed
// drive     drive_valid   drive_stall   drive_value
// config    cfg_write     -             cfg_index, cfg_data
//
// one beat in per cycle unless a stall holds it; stages: input reg, error/integral, products,
// sum, scale and saturate. the integral and previous error update as each beat is taken,
// so back-to-back beats see each other's state. each stage holds its beat while
// the next is full and stalled; empty stages still fill. rst clears the integral,
// previous error and valids, and reloads the gain and limit defaults.
module pid_speed_integral_separation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [pse_pkg::DATA_W-1:0]   target_speed,
  input  logic signed [pse_pkg::DATA_W-1:0]   measured_speed,
  output logic                                drive_valid,
  input  logic                                drive_stall,
  output logic signed [pse_pkg::DATA_W-1:0]   drive_value,
  input  logic                                cfg_write,
  input  logic [pse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pse_pkg::DATA_W-1:0]          cfg_data
);

  pse_pkg::cfg_t   cfg;
  pse_pkg::terms_t terms;
  pse_pkg::prods_t prods;

  logic                               in_valid;
  logic                               in_ready;
  logic signed [pse_pkg::DATA_W-1:0]  in_target;
  logic signed [pse_pkg::DATA_W-1:0]  in_measured;
  logic                               state_ready;
  logic                               terms_valid;
  logic                               mult_ready;
  logic                               prods_valid;
  logic                               out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_prop        <= pse_pkg::GAIN_PROP_RESET;
      cfg.gain_integ       <= pse_pkg::GAIN_INTEG_RESET;
      cfg.gain_deriv       <= pse_pkg::GAIN_DERIV_RESET;
      cfg.separation_limit <= pse_pkg::SEP_LIMIT_RESET;
    end else if (cfg_write) begin
      case (pse_pkg::cfg_reg_t'(cfg_index))
        pse_pkg::REG_GAIN_PROP:  cfg.gain_prop        <= cfg_data;
        pse_pkg::REG_GAIN_INTEG: cfg.gain_integ       <= cfg_data;
        pse_pkg::REG_GAIN_DERIV: cfg.gain_deriv       <= cfg_data;
        pse_pkg::REG_SEP_LIMIT:  cfg.separation_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready     = !in_valid || state_ready;
  assign sample_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && in_ready) begin
      in_target   <= target_speed;
      in_measured <= measured_speed;
    end
  end

  pse_state u_state (
    .clk            (clk),
    .rst            (rst),
    .up_valid       (in_valid),
    .up_ready       (state_ready),
    .target_speed   (in_target),
    .measured_speed (in_measured),
    .cfg            (cfg),
    .dn_valid       (terms_valid),
    .dn_ready       (mult_ready),
    .terms          (terms)
  );

  pse_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .up_valid (terms_valid),
    .up_ready (mult_ready),
    .terms    (terms),
    .cfg      (cfg),
    .dn_valid (prods_valid),
    .dn_ready (out_ready),
    .prods    (prods)
  );

  pse_out u_out (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (prods_valid),
    .up_ready    (out_ready),
    .prods       (prods),
    .dn_valid    (drive_valid),
    .dn_stall    (drive_stall),
    .drive_value (drive_value)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic signed [pse_pkg::DATA_W-1:0] tgt;
    logic signed [pse_pkg::DATA_W-1:0] meas;
  } speed_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [pse_pkg::DATA_W-1:0] target_speed = '0;
  logic signed [pse_pkg::DATA_W-1:0] measured_speed = '0;
  logic drive_valid;
  logic drive_stall = 1'b0;
  logic signed [pse_pkg::DATA_W-1:0] drive_value;
  logic cfg_write = 1'b0;
  logic [pse_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pse_pkg::DATA_W-1:0] cfg_data = '0;

  speed_sample_t pending_samples[$];
  speed_sample_t next_sample;
  logic signed [pse_pkg::DATA_W-1:0] expected_drive[$];
  logic signed [pse_pkg::DATA_W-1:0] drive_want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // controller state as the block should hold it
  logic signed [pse_pkg::DATA_W-1:0] pid_kp = pse_pkg::GAIN_PROP_RESET;
  logic signed [pse_pkg::DATA_W-1:0] pid_ki = pse_pkg::GAIN_INTEG_RESET;
  logic signed [pse_pkg::DATA_W-1:0] pid_kd = pse_pkg::GAIN_DERIV_RESET;
  logic [pse_pkg::DATA_W-1:0] pid_sep_limit = pse_pkg::SEP_LIMIT_RESET;
  longint integ_acc = 0;
  longint last_err = 0;

  pid_speed_integral_separation u_dut (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .target_speed   (target_speed),
    .measured_speed (measured_speed),
    .drive_valid    (drive_valid),
    .drive_stall    (drive_stall),
    .drive_value    (drive_value),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic signed [pse_pkg::DATA_W-1:0] predict_drive(
    logic signed [pse_pkg::DATA_W-1:0] tgt, logic signed [pse_pkg::DATA_W-1:0] meas);
    longint err, mag, acc, q;
    err = longint'(tgt) - longint'(meas);
    mag = (err < 0) ? -err : err;
    // integral separation: large errors leave the integral alone
    if (mag <= longint'(pid_sep_limit)) begin
      integ_acc = integ_acc + err;
      if (integ_acc > longint'(pse_pkg::SUM_MAX)) integ_acc = longint'(pse_pkg::SUM_MAX);
      else if (integ_acc < longint'(pse_pkg::SUM_MIN)) integ_acc = longint'(pse_pkg::SUM_MIN);
    end
    acc = longint'(pid_kp) * err + longint'(pid_ki) * integ_acc
        + longint'(pid_kd) * (err - last_err);
    last_err = err;
    // signed division truncates toward zero
    q = acc / (longint'(1) <<< pse_pkg::FRAC_BITS);
    if (q > longint'(pse_pkg::DRIVE_MAX)) q = longint'(pse_pkg::DRIVE_MAX);
    else if (q < longint'(pse_pkg::DRIVE_MIN)) q = longint'(pse_pkg::DRIVE_MIN);
    return pse_pkg::DATA_W'(q);
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall)
        expected_drive.push_back(predict_drive(target_speed, measured_speed));
      if (!sample_valid || !sample_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_sample = pending_samples.pop_front();
          sample_valid <= 1'b1;
          target_speed <= next_sample.tgt;
          measured_speed <= next_sample.meas;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // drive monitor
  always @(posedge clk) begin
    if (rst) begin
      drive_stall <= 1'b0;
    end else begin
      if (drive_valid && !drive_stall) begin
        if (expected_drive.size() == 0) begin
          $error("drive_value beat with nothing expected: actual %0d", drive_value);
          fail_count++;
        end else begin
          drive_want = expected_drive.pop_front();
          if (drive_value !== drive_want) begin
            $error("drive_value mismatch: expected %0d, actual %0d", drive_want, drive_value);
            fail_count++;
          end
        end
      end
      drive_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (!(pending_samples.size() == 0 && !sample_valid && expected_drive.size() == 0));
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(pse_pkg::cfg_reg_t idx, logic [pse_pkg::DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      pse_pkg::REG_GAIN_PROP:  pid_kp = val;
      pse_pkg::REG_GAIN_INTEG: pid_ki = val;
      pse_pkg::REG_GAIN_DERIV: pid_kd = val;
      pse_pkg::REG_SEP_LIMIT:  pid_sep_limit = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_gains(logic [pse_pkg::DATA_W-1:0] kp, logic [pse_pkg::DATA_W-1:0] ki,
                             logic [pse_pkg::DATA_W-1:0] kd, logic [pse_pkg::DATA_W-1:0] lim);
    wait_drained();
    write_reg(pse_pkg::REG_GAIN_PROP, kp);
    write_reg(pse_pkg::REG_GAIN_INTEG, ki);
    write_reg(pse_pkg::REG_GAIN_DERIV, kd);
    write_reg(pse_pkg::REG_SEP_LIMIT, lim);
    @(negedge clk);
  endtask

  task automatic push_sample(int t, int m);
    pending_samples.push_back(speed_sample_t'{pse_pkg::DATA_W'(t), pse_pkg::DATA_W'(m)});
  endtask

  // mostly tracking samples with small errors, some near the separation limit, some noise
  task automatic push_random_sample();
    int t, m, d, sel;
    t = int'($urandom_range(0, 65535)) - 32768;
    sel = $urandom_range(99);
    if (sel < 55) begin
      d = int'($urandom_range(0, 800)) - 400;
      m = t - d;
    end else if (sel < 80) begin
      d = int'(pid_sep_limit) + int'($urandom_range(0, 2)) - 1;
      m = ($urandom_range(1)) ? t - d : t + d;
    end else begin
      m = int'($urandom_range(0, 65535)) - 32768;
    end
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;
    push_sample(t, m);
  endtask

  task automatic run_random_phase(logic [pse_pkg::DATA_W-1:0] kp,
                                  logic [pse_pkg::DATA_W-1:0] ki,
                                  logic [pse_pkg::DATA_W-1:0] kd,
                                  logic [pse_pkg::DATA_W-1:0] lim,
                                  int send_pct, int recv_pct);
    apply_gains(kp, ki, kd, lim);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    // batches with a full drain in between so the sender sits idle
    repeat (4) begin
      repeat (40) push_random_sample();
      wait_drained();
    end
  endtask

  initial begin
    send_idle_pct = 31;
    recv_idle_pct = 65;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed beats at reset gains
    push_sample(0, 0);
    push_sample(300, 0);
    push_sample(0, 300);
    push_sample(301, 0);
    push_sample(0, 301);
    push_sample(-150, 150);
    push_sample(32767, -32768);
    push_sample(-32768, 32767);
    push_sample(32767, 32767);
    push_sample(-32768, -32768);
    push_sample(-32768, 0);
    push_sample(0, -32768);
    push_sample(1, 0);
    push_sample(-1, 0);
    push_sample(-5, 0);
    push_sample(100, -100);
    push_sample(-299, 0);
    wait_drained();

    run_random_phase(16'h8000, 16'h7fff, 16'h8000, 16'h0000, 31, 65);
    run_random_phase(16'h7fff, 16'h8000, 16'h7fff, 16'hffff, 31, 65);
    run_random_phase(16'd300, 16'd20, 16'd150, 16'd2000, 65, 31);
    run_random_phase(pse_pkg::DATA_W'($urandom), pse_pkg::DATA_W'($urandom),
                     pse_pkg::DATA_W'($urandom),
                     pse_pkg::DATA_W'($urandom_range(0, 4000)), 65, 31);
    run_random_phase(pse_pkg::GAIN_PROP_RESET, pse_pkg::GAIN_INTEG_RESET,
                     pse_pkg::GAIN_DERIV_RESET, pse_pkg::SEP_LIMIT_RESET, 0, 0);

    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
